[rtl/bth_pkg.sv]
// Shared types and constants for the boundary-tag heap allocator.
package bth_pkg;

  localparam int unsigned HeapBytesDef    = 1024;
  localparam int unsigned ElementBytesDef = 8;
  localparam int unsigned TagBytesDef     = 4;
  localparam int unsigned MaxResults      = 64;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_DUMP  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_NOBUSY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_CLEAR = 3'd1,
    WR_AHEAD = 3'd2,
    WR_AREM  = 3'd3,
    WR_FCUR  = 3'd4,
    WR_FPREV = 3'd5
  } wr_e;

  typedef struct packed {
    logic    start;
    logic    rd_cur;
    logic    rd_next;
    logic    lat_sz;
    logic    adv;
    logic    merge_next;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_one;
    wr_e     wr;
    logic    set_res;
    status_e res_st;
    logic    res_off;
    logic    emit_res;
    logic    emit_dump;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  n_zero;
    logic  k_zero;
    logic  at_end;
    logic  fits;
    logic  split_ok;
    logic  seen_hit;
    logic  nxt_end;
    logic  dump_last;
    logic  prv_merge;
    logic  nxt_free;
    logic  out_free;
  } sts_t;

endpackage

[rtl/boundary_tag_heap_allocator.sv]
// Top level: boundary-tag first-fit heap allocator with coalescing.
// Allocate and free walk the tags from the heap start, block by block; dump gives
// one transaction per block, at most MaxResults of them; clear rewrites the head tag.
// The walk runs through the tag memory, and a new request is taken only once the
// last one is done and its result has been handed to the output register.
// Reset: one whole free block, no clearing pass; control state clears at once.
module boundary_tag_heap_allocator import bth_pkg::*; #(
  parameter int unsigned HEAP_BYTES    = HeapBytesDef,
  parameter int unsigned ELEMENT_BYTES = ElementBytesDef,
  parameter int unsigned TAG_BYTES     = TagBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // elem_count[6:0], busy_index[13:7], zero pad
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status[1:0], data_offset[11:2], tag_value[22:12]
  output logic        m_axis_tlast    // last
);

  cmd_t        cmd;
  sts_t        sts;
  logic [1:0]  status;
  logic [9:0]  data_offset;
  logic [10:0] tag_value;

  bth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bth_datapath #(
    .HEAP_BYTES    (HEAP_BYTES),
    .ELEMENT_BYTES (ELEMENT_BYTES),
    .TAG_BYTES     (TAG_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (s_axis_tuser),
    .elem_count_i  (s_axis_tdata[6:0]),
    .busy_index_i  (s_axis_tdata[13:7]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .status_o      (status),
    .data_offset_o (data_offset),
    .tag_value_o   (tag_value),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, tag_value, data_offset, status};

endmodule

[rtl/bth_datapath.sv]
// Datapath: tag memory, scan pointers, block count and result register.
module bth_datapath import bth_pkg::*; #(
  parameter int unsigned HEAP_BYTES    = HeapBytesDef,
  parameter int unsigned ELEMENT_BYTES = ElementBytesDef,
  parameter int unsigned TAG_BYTES     = TagBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  func_i,
  input  logic [6:0]  elem_count_i,
  input  logic [6:0]  busy_index_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  status_o,
  output logic [9:0]  data_offset_o,
  output logic [10:0] tag_value_o,
  output logic        last_o
);

  localparam int unsigned SW   = $clog2(HEAP_BYTES);        // stored size bits
  localparam int unsigned AW   = $clog2(HEAP_BYTES);        // memory address bits
  localparam int unsigned PW   = $clog2(HEAP_BYTES + 1);    // pointer, holds the end
  localparam int unsigned NW   = 7 + $clog2(ELEMENT_BYTES) + 1;
  localparam int unsigned WM   = (NW > PW) ? NW : PW;
  localparam int unsigned WW   = ((WM > 12) ? WM : 12) + 1;
  localparam int unsigned MaxBlocks = HEAP_BYTES / (2 * TAG_BYTES + ELEMENT_BYTES) + 2;
  localparam int unsigned CW   = $clog2(MaxBlocks + 1);
  localparam int unsigned RW   = $clog2(MaxResults);
  localparam logic [WW-1:0] T2   = WW'(2 * TAG_BYTES);
  localparam logic [WW-1:0] Tb   = WW'(TAG_BYTES);
  localparam logic [WW-1:0] Hb   = WW'(HEAP_BYTES);
  localparam logic [WW-1:0] Spl  = WW'(2 * TAG_BYTES + ELEMENT_BYTES);
  localparam logic [WW-1:0] Init = WW'(HEAP_BYTES - 2 * TAG_BYTES);

  logic [SW:0]    mem_q [HEAP_BYTES];   // {busy, payload size}, by byte address
  logic [SW:0]    rd_q;
  logic           rd_zero_q, hv_q;
  logic [WW-1:0]  cur_q, prv_q, prv_size_q, sz_q, need_q;
  logic           prv_busy_q, prv_has_q;
  logic [6:0]     seen_q, k_q;
  logic           n_zero_q;
  func_e          func_q;
  logic [CW-1:0]  cnt_q;
  logic [RW-1:0]  nres_q;
  status_e        res_st_q;
  logic [9:0]     res_off_q;
  logic           out_valid_q;

  logic [WW-1:0]  tsize, nxt, rd_addr, wr_addr, wr_size;
  logic           tbusy, wr_en, wr_busy, out_free;
  logic [WW-1:0]  tag_s;

  // head tag reads as the whole free heap until first written
  assign tbusy = (rd_zero_q && !hv_q) ? 1'b0 : rd_q[SW];
  assign tsize = (rd_zero_q && !hv_q) ? Init : WW'(rd_q[SW-1:0]);
  assign nxt   = cur_q + tsize + T2;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.func      = func_q;
    sts_o.n_zero    = n_zero_q;
    sts_o.k_zero    = (k_q == 7'd0);
    sts_o.at_end    = (cur_q == Hb);
    sts_o.fits      = !tbusy && (tsize >= need_q);
    sts_o.split_ok  = ((tsize - need_q) >= Spl) && (WW'(cnt_q) < WW'(MaxBlocks));
    sts_o.seen_hit  = tbusy && ((seen_q + 7'd1) == k_q);
    sts_o.nxt_end   = (nxt == Hb);
    sts_o.dump_last = (nxt == Hb) || (nres_q == RW'(MaxResults - 1));
    sts_o.prv_merge = prv_has_q && !prv_busy_q;
    sts_o.nxt_free  = !tbusy;
    sts_o.out_free  = out_free;
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur_q;
    wr_busy = 1'b0;
    wr_size = sz_q;
    case (cmd_i.wr)
      WR_CLEAR: begin
        wr_addr = '0;
        wr_size = Init;
      end
      WR_AHEAD: begin
        wr_busy = 1'b1;
        wr_size = sts_o.split_ok ? need_q : tsize;
      end
      // size latched at the head write; the head may have just become written
      WR_AREM: begin
        wr_addr = cur_q + need_q + T2;
        wr_size = sz_q - need_q - T2;
      end
      WR_FCUR:  wr_size = sz_q;
      WR_FPREV: begin
        wr_addr = prv_q;
        wr_size = prv_size_q + sz_q + T2;
      end
      default:  wr_en = 1'b0;
    endcase
  end

  assign rd_addr = cmd_i.rd_next ? nxt : cur_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[AW-1:0]] <= {wr_busy, wr_size[SW-1:0]};
    end
    if (cmd_i.rd_cur || cmd_i.rd_next) begin
      rd_q <= mem_q[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q        <= 1'b0;
      rd_zero_q   <= 1'b0;
      cnt_q       <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en && (wr_addr == '0)) hv_q <= 1'b1;
      if (cmd_i.rd_cur || cmd_i.rd_next) rd_zero_q <= (rd_addr == '0);
      if (cmd_i.cnt_one) cnt_q <= CW'(1);
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
      else if (cmd_i.cnt_dec) cnt_q <= cnt_q - CW'(1);
      if (cmd_i.emit_res || cmd_i.emit_dump) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign tag_s = tbusy ? (WW'(0) - tsize) : tsize;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q     <= func_e'(func_i);
      n_zero_q   <= (elem_count_i == 7'd0);
      need_q     <= WW'(elem_count_i) * WW'(ELEMENT_BYTES);
      k_q        <= busy_index_i;
      cur_q      <= '0;
      seen_q     <= '0;
      prv_has_q  <= 1'b0;
      nres_q     <= '0;
    end
    if (cmd_i.adv) begin
      prv_q      <= cur_q;
      prv_busy_q <= tbusy;
      prv_size_q <= tsize;
      prv_has_q  <= 1'b1;
      cur_q      <= nxt;
      if (tbusy) seen_q <= seen_q + 7'd1;
    end
    if (cmd_i.lat_sz) sz_q <= tsize;
    else if (cmd_i.merge_next) sz_q <= sz_q + tsize + T2;
    if (cmd_i.set_res) begin
      res_st_q  <= cmd_i.res_st;
      res_off_q <= cmd_i.res_off ? 10'(cur_q + Tb) : 10'd0;
    end
    if (cmd_i.emit_res) begin
      status_o      <= res_st_q;
      data_offset_o <= res_off_q;
      tag_value_o   <= '0;
      last_o        <= 1'b1;
    end else if (cmd_i.emit_dump) begin
      status_o      <= ST_OK;
      data_offset_o <= '0;
      tag_value_o   <= tag_s[10:0];
      last_o        <= sts_o.dump_last;
      nres_q        <= nres_q + RW'(1);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/bth_ctrl.sv]
// Controller: sequences scans, splits, merges and result hand-off.
module bth_ctrl import bth_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_AREM  = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_MPREV = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;   // result parked, waiting for the output register

  assign in_ready_o = (state_q == S_IDLE) && !fin_q;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.wr = WR_NONE;
    cmd_o.res_st = ST_OK;
    if (fin_q) begin
      if (sts_i.out_free) begin
        cmd_o.emit_res = 1'b1;
        fin_d = 1'b0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.start = 1'b1;
            state_d = S_DISP;
          end
        end
        S_DISP: begin
          state_d = S_IDLE;
          unique case (sts_i.func)
            FUNC_CLEAR: begin
              cmd_o.wr = WR_CLEAR;
              cmd_o.cnt_one = 1'b1;
              cmd_o.set_res = 1'b1;
              fin_d = 1'b1;
            end
            FUNC_ALLOC: begin
              if (sts_i.n_zero) begin
                cmd_o.set_res = 1'b1;
                cmd_o.res_st = ST_NOFIT;
                fin_d = 1'b1;
              end else state_d = S_RD;
            end
            FUNC_FREE: begin
              if (sts_i.k_zero) begin
                cmd_o.set_res = 1'b1;
                cmd_o.res_st = ST_NOBUSY;
                fin_d = 1'b1;
              end else state_d = S_RD;
            end
            default: state_d = S_RD;
          endcase
        end
        S_RD: begin
          if (sts_i.at_end) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_st = (sts_i.func == FUNC_ALLOC) ? ST_NOFIT : ST_NOBUSY;
            fin_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_cur = 1'b1;
            state_d = S_EVAL;
          end
        end
        S_EVAL: begin
          case (sts_i.func)
            FUNC_ALLOC: begin
              if (sts_i.fits) begin
                cmd_o.wr = WR_AHEAD;
                cmd_o.lat_sz = 1'b1;
                if (sts_i.split_ok) state_d = S_AREM;
                else begin
                  cmd_o.set_res = 1'b1;
                  cmd_o.res_off = 1'b1;
                  fin_d = 1'b1;
                  state_d = S_IDLE;
                end
              end else begin
                cmd_o.adv = 1'b1;
                state_d = S_RD;
              end
            end
            FUNC_FREE: begin
              if (sts_i.seen_hit) begin
                cmd_o.lat_sz = 1'b1;
                if (sts_i.nxt_end) state_d = S_MPREV;
                else begin
                  cmd_o.rd_next = 1'b1;
                  state_d = S_NEXT;
                end
              end else begin
                cmd_o.adv = 1'b1;
                state_d = S_RD;
              end
            end
            default: begin
              if (sts_i.out_free) begin
                cmd_o.emit_dump = 1'b1;
                cmd_o.adv = 1'b1;
                state_d = sts_i.dump_last ? S_IDLE : S_RD;
              end
            end
          endcase
        end
        S_AREM: begin
          cmd_o.wr = WR_AREM;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.set_res = 1'b1;
          cmd_o.res_off = 1'b1;
          fin_d = 1'b1;
          state_d = S_IDLE;
        end
        S_NEXT: begin
          if (sts_i.nxt_free) begin
            cmd_o.merge_next = 1'b1;
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = S_MPREV;
        end
        S_MPREV: begin
          if (sts_i.prv_merge) begin
            cmd_o.wr = WR_FPREV;
            cmd_o.cnt_dec = 1'b1;
          end else cmd_o.wr = WR_FCUR;
          cmd_o.set_res = 1'b1;
          fin_d = 1'b1;
          state_d = S_IDLE;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule
